>>> src/sspk_pkg.sv
// Shared types and constants for the spectrum saturation peak scan block.
`timescale 1ns / 1ps

package sspk_pkg;

  // Field widths
  localparam int PIX_W      = 12;
  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOW_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LEVEL  = 3'd4;

  // Register reset values (saturation level is 98 percent of full scale)
  localparam logic [PIX_W-1:0]    RST_LOW_START  = 12'd539;
  localparam logic [PIX_W-1:0]    RST_LOW_END    = 12'd664;
  localparam logic [PIX_W-1:0]    RST_HIGH_START = 12'd722;
  localparam logic [PIX_W-1:0]    RST_HIGH_END   = 12'd857;
  localparam logic [SAMPLE_W-1:0] RST_SAT_LEVEL  = 16'd64224;

  // Empty-window peak value
  localparam logic signed [PEAK_W-1:0] PEAK_EMPTY = -17'sd1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // Configuration register set
  typedef struct packed {
    logic [PIX_W-1:0]    low_start;
    logic [PIX_W-1:0]    low_end;
    logic [PIX_W-1:0]    high_start;
    logic [PIX_W-1:0]    high_end;
    logic [SAMPLE_W-1:0] sat_level;
  } cfg_t;

  // One classified sample, as the front hands it to the back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic [PIX_W-1:0]    idx;
    logic                in_peak;
    logic                in_low;
    logic                in_high;
    logic                sat;
  } item_t;

endpackage

>>> src/sspk_front.sv
// Front end: numbers pixels and classifies each sample against the windows.
`timescale 1ns / 1ps

module sspk_front #(
  parameter int SPECTRUM_LENGTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sspk_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sspk_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_last,
  input  logic                          q_full,
  output logic                          q_push,
  output sspk_pkg::item_t               q_item
);

  localparam int IDX_W = $clog2(SPECTRUM_LENGTH);
  localparam logic [IDX_W:0] LEN = (IDX_W+1)'(SPECTRUM_LENGTH);

  logic [IDX_W-1:0]          idx_r;
  logic [IDX_W-1:0]          idx_nxt;
  logic [IDX_W:0]            idx_inc;
  logic [sspk_pkg::PIX_W-1:0] pix;

  // Hold off requests while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  assign pix     = sspk_pkg::PIX_W'(idx_r);
  assign idx_inc = {1'b0, idx_r} + (IDX_W+1)'(1);

  // Advance the pixel counter, wrapping at the spectrum length or after a last sample
  always_comb begin
    idx_nxt = idx_r;
    if (q_push) begin
      if (in_last || idx_inc == LEN) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Classify the sample against the peak, low and high windows and the sat level
  always_comb begin
    q_item.sample  = in_sample;
    q_item.last    = in_last;
    q_item.idx     = pix;
    q_item.in_peak = (pix >= cfg.low_start) && (pix < cfg.high_end);
    q_item.in_low  = (pix >= cfg.low_start) && (pix < cfg.low_end);
    q_item.in_high = (pix >= cfg.high_start) && (pix < cfg.high_end);
    q_item.sat     = in_sample >= cfg.sat_level;
  end

endmodule

>>> src/sspk_queue.sv
// Short queue of classified samples between the front and the back.
`timescale 1ns / 1ps

module sspk_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sspk_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output sspk_pkg::item_t pop_item
);

  sspk_pkg::item_t                  mem_r [sspk_pkg::QUEUE_DEPTH];
  logic [sspk_pkg::QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [sspk_pkg::QUEUE_PTR_W-1:0] wr_ptr_nxt;
  logic [sspk_pkg::QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [sspk_pkg::QUEUE_PTR_W-1:0] rd_ptr_nxt;
  logic [sspk_pkg::QUEUE_CNT_W-1:0] cnt_r;
  logic [sspk_pkg::QUEUE_CNT_W-1:0] cnt_nxt;
  logic                             do_pop;

  assign full      = cnt_r == sspk_pkg::QUEUE_CNT_W'(sspk_pkg::QUEUE_DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_pop    = pop & pop_valid;

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + sspk_pkg::QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + sspk_pkg::QUEUE_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + sspk_pkg::QUEUE_CNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - sspk_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/sspk_back.sv
// Back end: tracks peak and first saturated pixels, emits one result per spectrum.
`timescale 1ns / 1ps

module sspk_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sspk_pkg::cfg_t                       cfg,
  input  logic                                 q_valid,
  input  sspk_pkg::item_t                      q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sspk_pkg::PEAK_W-1:0]   out_peak,
  output logic [sspk_pkg::PIX_W-1:0]           out_sat_count_low,
  output logic [sspk_pkg::PIX_W-1:0]           out_sat_count_high
);

  logic signed [sspk_pkg::PEAK_W-1:0] peak_r, peak_nxt;
  logic                               peak_sat_r, peak_sat_nxt;
  logic                               low_seen_r, low_seen_nxt;
  logic [sspk_pkg::PIX_W-1:0]         low_idx_r, low_idx_nxt;
  logic                               high_seen_r, high_seen_nxt;
  logic [sspk_pkg::PIX_W-1:0]         high_idx_r, high_idx_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [sspk_pkg::PEAK_W-1:0] out_peak_r;
  logic [sspk_pkg::PIX_W-1:0]         cnt_lo_r, cnt_hi_r;
  logic [sspk_pkg::PIX_W-1:0]         cnt_lo, cnt_hi;

  logic                               out_free;
  logic                               emit;
  logic signed [sspk_pkg::PEAK_W-1:0] sample_s;
  logic                               take_peak;
  logic                               low_hit, high_hit;

  // Plain samples pass freely; a last sample waits for the output register
  assign out_free = ~out_valid_r | ~out_stall;
  assign q_pop    = q_valid & (~q_item.last | out_free);
  assign emit     = q_pop & q_item.last;

  assign sample_s  = $signed({1'b0, q_item.sample});
  assign take_peak = q_item.in_peak && (sample_s > peak_r);
  assign low_hit   = q_item.sat && q_item.in_low && !low_seen_r;
  assign high_hit  = q_item.sat && q_item.in_high && !high_seen_r;

  // Update the running spectrum state
  always_comb begin
    peak_nxt      = take_peak ? sample_s : peak_r;
    peak_sat_nxt  = peak_sat_r | (q_item.in_peak & q_item.sat);
    low_seen_nxt  = low_seen_r | low_hit;
    low_idx_nxt   = low_hit ? q_item.idx : low_idx_r;
    high_seen_nxt = high_seen_r | high_hit;
    high_idx_nxt  = high_hit ? q_item.idx : high_idx_r;
  end

  // Derive the saturation counts from the state including this sample
  always_comb begin
    cnt_lo = '0;
    cnt_hi = '0;
    if (peak_sat_nxt) begin
      if (low_seen_nxt) begin
        cnt_lo = cfg.low_end - low_idx_nxt - sspk_pkg::PIX_W'(1);
        cnt_hi = cfg.high_end - cfg.high_start + sspk_pkg::PIX_W'(1);
      end else if (high_seen_nxt) begin
        cnt_hi = cfg.high_end - high_idx_nxt - sspk_pkg::PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= sspk_pkg::PEAK_EMPTY;
      peak_sat_r  <= 1'b0;
      low_seen_r  <= 1'b0;
      low_idx_r   <= '0;
      high_seen_r <= 1'b0;
      high_idx_r  <= '0;
    end else if (q_pop) begin
      if (q_item.last) begin
        peak_r      <= sspk_pkg::PEAK_EMPTY;
        peak_sat_r  <= 1'b0;
        low_seen_r  <= 1'b0;
        low_idx_r   <= '0;
        high_seen_r <= 1'b0;
        high_idx_r  <= '0;
      end else begin
        peak_r      <= peak_nxt;
        peak_sat_r  <= peak_sat_nxt;
        low_seen_r  <= low_seen_nxt;
        low_idx_r   <= low_idx_nxt;
        high_seen_r <= high_seen_nxt;
        high_idx_r  <= high_idx_nxt;
      end
    end
  end

  // Hold the result until the downstream side takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_peak_r <= peak_nxt;
      cnt_lo_r   <= cnt_lo;
      cnt_hi_r   <= cnt_hi;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_peak           = out_peak_r;
  assign out_sat_count_low  = cnt_lo_r;
  assign out_sat_count_high = cnt_hi_r;

endmodule

>>> src/spectrum_saturation_peak_scan.sv
// Top level of the spectrum saturation peak scan: configuration registers and wiring.
`timescale 1ns / 1ps

// Takes one detector sample per clock while in_stall is low, numbering pixels from 0
// (wrapping after SPECTRUM_LENGTH-1 and restarting after each last sample). A front
// stage classifies each sample against the configured windows and pushes it into a
// four-entry queue; a back stage tracks the peak over [low_start, high_end) and the
// first saturated pixel in the low and high windows, and on the last sample loads
// one result into an output register. Sustained rate is one sample per clock while
// no result waits, set by the compare-and-update in the back stage. A last sample
// passes the queue and then the output register; samples keep flowing while a result
// waits, until the queue fills. Registers are written through cfg_we/cfg_index/
// cfg_data, by the user while no spectrum is in flight; the block does not check it.

module spectrum_saturation_peak_scan #(
  parameter int SPECTRUM_LENGTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [sspk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sspk_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [sspk_pkg::SAMPLE_W-1:0]          in_sample,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [sspk_pkg::PEAK_W-1:0]     out_peak,
  output logic [sspk_pkg::PIX_W-1:0]             out_sat_count_low,
  output logic [sspk_pkg::PIX_W-1:0]             out_sat_count_high
);

  sspk_pkg::cfg_t  cfg_r;
  sspk_pkg::cfg_t  cfg_nxt;
  sspk_pkg::item_t push_item;
  sspk_pkg::item_t pop_item;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sspk_pkg::REG_LOW_START:  cfg_nxt.low_start  = cfg_data[sspk_pkg::PIX_W-1:0];
        sspk_pkg::REG_LOW_END:    cfg_nxt.low_end    = cfg_data[sspk_pkg::PIX_W-1:0];
        sspk_pkg::REG_HIGH_START: cfg_nxt.high_start = cfg_data[sspk_pkg::PIX_W-1:0];
        sspk_pkg::REG_HIGH_END:   cfg_nxt.high_end   = cfg_data[sspk_pkg::PIX_W-1:0];
        sspk_pkg::REG_SAT_LEVEL:  cfg_nxt.sat_level  = cfg_data[sspk_pkg::SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_start  <= sspk_pkg::RST_LOW_START;
      cfg_r.low_end    <= sspk_pkg::RST_LOW_END;
      cfg_r.high_start <= sspk_pkg::RST_HIGH_START;
      cfg_r.high_end   <= sspk_pkg::RST_HIGH_END;
      cfg_r.sat_level  <= sspk_pkg::RST_SAT_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sspk_front #(
    .SPECTRUM_LENGTH(SPECTRUM_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_sample(in_sample),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  sspk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_item (pop_item)
  );

  sspk_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_peak          (out_peak),
    .out_sat_count_low (out_sat_count_low),
    .out_sat_count_high(out_sat_count_high)
  );

endmodule
